// ===== design/bfvc_pkg.sv =====
// Shared types, codes and the per-byte frame tracking function of the frame checker.
`default_nettype none

package bfvc_pkg;

    // Configuration port geometry and register indexes
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_START_WORD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_END_MARKER = 1'b1;

    // Register reset values
    localparam logic [15:0] START_WORD_RST = 16'h4E57;
    localparam logic [7:0]  END_MARKER_RST = 8'h68;

    // Smallest frame span that can be checked
    localparam logic [16:0] MIN_SPAN = 17'd5;
    // Count of header bytes (start word plus length field)
    localparam logic [16:0] HDR_BYTES = 17'd4;

    typedef enum logic [1:0] {
        ST_ACCEPT   = 2'd0,
        ST_CTRL_ERR = 2'd1,
        ST_SUM_ERR  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        COV_FULL      = 2'd0,
        COV_END_ONLY  = 2'd1,
        COV_UNCHECKED = 2'd2
    } coverage_t;

    typedef struct packed {
        status_t   status;
        coverage_t coverage;
    } result_t;

    typedef struct packed {
        logic [15:0] byte_position;
        logic [15:0] frame_length;
        logic [15:0] running_sum;
        logic        start_ok;
        logic        end_ok;
        logic        sum_field_ok;
    } track_t;

    // Fold one frame byte at position q into the tracking state for span f.
    function automatic track_t take(input track_t st, input logic [15:0] q,
                                    input logic [7:0] b, input logic [15:0] f,
                                    input logic [7:0] em);
        logic [16:0] q17;
        logic [16:0] f17;
        track_t      r;
        q17 = {1'b0, q};
        f17 = {1'b0, f};
        r   = st;
        if (f17 >= MIN_SPAN && q17 < f17) begin
            if (q17 + 17'd5 <= f17) begin
                r.running_sum = st.running_sum + {8'h00, b};
            end
            if (q17 + 17'd5 == f17) begin
                r.end_ok = (b == em);
            end
            if (q17 + 17'd4 == f17 || q17 + 17'd3 == f17) begin
                r.sum_field_ok = st.sum_field_ok && (b == 8'h00);
            end
            if (q17 + 17'd2 == f17) begin
                r.sum_field_ok = st.sum_field_ok && (b == st.running_sum[15:8]);
            end
            if (q17 + 17'd1 == f17) begin
                r.sum_field_ok = st.sum_field_ok && (b == st.running_sum[7:0]);
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== design/bfvc_track.sv =====
// Frame tracking state: position, length, running sum, match flags and the final verdict.
`default_nettype none

module bfvc_track (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              step_en,
    input  wire logic [7:0]        byte_value,
    input  wire logic              last_byte,
    input  wire logic [15:0]       start_word,
    input  wire logic [7:0]        end_marker,
    output bfvc_pkg::result_t      result
);

    bfvc_pkg::track_t state_reg;
    bfvc_pkg::track_t state_next;
    bfvc_pkg::track_t upd;
    logic [15:0]      span;
    logic [7:0]       hdr [4];
    logic [16:0]      n17;
    logic [16:0]      f17;

    always_comb begin
        upd    = state_reg;
        span   = state_reg.frame_length + 16'd2;
        hdr[0] = start_word[15:8];
        hdr[1] = start_word[7:0];
        hdr[2] = state_reg.frame_length[15:8];
        hdr[3] = byte_value;
        case (state_reg.byte_position)
            16'd0: begin
                upd.start_ok = (byte_value == start_word[15:8]);
            end
            16'd1: begin
                upd.start_ok = state_reg.start_ok && (byte_value == start_word[7:0]);
            end
            16'd2: begin
                upd.frame_length = {byte_value, 8'h00};
            end
            16'd3: begin
                // length complete: replay the four header bytes through the checker
                upd.frame_length = {state_reg.frame_length[15:8], byte_value};
                span             = upd.frame_length + 16'd2;
                upd.running_sum  = '0;
                upd.end_ok       = 1'b0;
                upd.sum_field_ok = 1'b1;
                for (int k = 0; k < 4; k++) begin
                    upd = bfvc_pkg::take(upd, 16'(k), hdr[k], span, end_marker);
                end
            end
            default: begin
                upd = bfvc_pkg::take(state_reg, state_reg.byte_position, byte_value,
                                     span, end_marker);
            end
        endcase
        if (state_reg.byte_position != 16'hFFFF) begin
            upd.byte_position = state_reg.byte_position + 16'd1;
        end
    end

    // verdict at the last byte of the buffer
    always_comb begin
        n17             = {1'b0, state_reg.byte_position} + 17'd1;
        f17             = {1'b0, upd.frame_length + 16'd2};
        result.status   = bfvc_pkg::ST_ACCEPT;
        result.coverage = bfvc_pkg::COV_FULL;
        if (n17 < bfvc_pkg::HDR_BYTES || !upd.start_ok || f17 < bfvc_pkg::MIN_SPAN) begin
            result.status = bfvc_pkg::ST_CTRL_ERR;
        end else if (n17 >= f17) begin
            if (!upd.end_ok) begin
                result.status = bfvc_pkg::ST_CTRL_ERR;
            end else if (!upd.sum_field_ok) begin
                result.status = bfvc_pkg::ST_SUM_ERR;
            end
        end else if (n17 + 17'd4 >= f17) begin
            result.coverage = bfvc_pkg::COV_END_ONLY;
            if (!upd.end_ok) begin
                result.status = bfvc_pkg::ST_CTRL_ERR;
            end
        end else begin
            result.coverage = bfvc_pkg::COV_UNCHECKED;
        end
    end

    // clear after the last byte so the next buffer starts fresh
    always_comb begin
        state_next = state_reg;
        if (step_en) begin
            state_next = last_byte ? '0 : upd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/bms_frame_validity_checker_core.sv =====
// Top level of the byte-sum frame checker: input register, tracker, result register, config.
// A last byte leaving the input register loads its verdict into the result register (m_*).
// Throughput: one byte per cycle; the input register is refilled in the cycle it drains.
// A waiting result stalls only a following last byte; other bytes keep flowing.
// Reset (synchronous, aresetn low): empties both registers, clears the frame tracking
// state and restores start_word 0x4E57 and end_marker 0x68.
`default_nettype none

module bms_frame_validity_checker_core (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // configuration write port
    input  wire logic                              cfg_wr_en,
    input  wire logic [bfvc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [bfvc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    // byte input channel
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [7:0]                        s_byte_value,
    input  wire logic                              s_last_byte,
    // result channel
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [1:0]                             m_status,
    output logic [1:0]                             m_coverage
);

    // configuration registers
    logic [15:0] start_word_reg;
    logic [7:0]  end_marker_reg;

    // input register
    logic        in_valid_reg;
    logic        in_valid_next;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;

    // result register
    logic               out_valid_reg;
    logic               out_valid_next;
    bfvc_pkg::result_t  out_reg;
    bfvc_pkg::result_t  track_result;

    logic advance;

    // Advance the held byte unless it is a last byte and the result slot is still full.
    assign advance = in_valid_reg && (!in_last_reg || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_word_reg <= bfvc_pkg::START_WORD_RST;
            end_marker_reg <= bfvc_pkg::END_MARKER_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                bfvc_pkg::REG_START_WORD: start_word_reg <= cfg_wdata;
                bfvc_pkg::REG_END_MARKER: end_marker_reg <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // Hold a byte in the input register; take a new one whenever the old one leaves.
    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_ready) begin
            in_valid_next = s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_byte_value;
            in_last_reg <= s_last_byte;
        end
    end

    bfvc_track u_track (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step_en    (advance),
        .byte_value (in_byte_reg),
        .last_byte  (in_last_reg),
        .start_word (start_word_reg),
        .end_marker (end_marker_reg),
        .result     (track_result)
    );

    // Load the verdict when a last byte advances; drop it once taken.
    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance && in_last_reg) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_last_reg) begin
            out_reg <= track_result;
        end
    end

    assign m_valid    = out_valid_reg;
    assign m_status   = out_reg.status;
    assign m_coverage = out_reg.coverage;

    // A result appears only after a last byte went through the tracker.
    a_result_from_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(advance && in_last_reg))
        else $error("result raised without a last item");

    // An unchecked tail can never carry an error.
    a_unchecked_accepts: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_reg.coverage == bfvc_pkg::COV_UNCHECKED)
            |-> out_reg.status == bfvc_pkg::ST_ACCEPT)
        else $error("unchecked tail reported with an error");

    // A checksum error is only possible on a fully received frame.
    a_sum_err_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_reg.status == bfvc_pkg::ST_SUM_ERR)
            |-> out_reg.coverage == bfvc_pkg::COV_FULL)
        else $error("checksum error on a partial frame");

    // A stalled last item must not overwrite a result still waiting.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready && in_valid_reg && in_last_reg) |=> $stable(out_reg))
        else $error("pending result overwritten");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the byte-sum frame checker core.
`timescale 1ns / 100ps

module tb;
    import bfvc_pkg::*;

    // Abandon the run after this many cycles without a single handshake
    localparam int unsigned STALL_LIMIT = 2000;
    // Cycles to let pass after the last result before touching the registers
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned DIRECTED_ROWS = 27;
    localparam int unsigned ITEMS_PER_SETTING = 270;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
        logic       typed;
        status_t    st;
        coverage_t  cv;
    } stim_row_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_valid;
    logic                  s_ready;
    logic [7:0]            s_byte_value;
    logic                  s_last_byte;
    logic                  m_valid;
    logic                  m_ready;
    logic [1:0]            m_status;
    logic [1:0]            m_coverage;

    bms_frame_validity_checker_core i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_byte_value (s_byte_value),
        .s_last_byte  (s_last_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_coverage   (m_coverage)
    );

    // Register values as the block should currently hold them
    logic [15:0] cfg_start  = START_WORD_RST;
    logic [7:0]  cfg_marker = END_MARKER_RST;

    // Frame tracking state of the predictor, cleared after every last byte
    logic [15:0] byte_pos       = '0;
    logic [15:0] frame_len      = '0;
    logic [15:0] acc_sum        = '0;
    logic        start_good     = 1'b0;
    logic        marker_good    = 1'b0;
    logic        sum_field_good = 1'b0;

    // Verdicts still owed by the block, oldest first
    result_t     verdict_q[$];
    // Bytes of the buffer being assembled for transmission
    logic [7:0]  frame_bytes[$];
    stim_row_t   directed_rows [DIRECTED_ROWS];

    int unsigned bytes_sent      = 0;
    int unsigned buffers_sent    = 0;
    int unsigned results_checked = 0;
    int unsigned mismatches      = 0;
    int unsigned idle_cycles     = 0;
    bit          src_burst       = 1'b0;
    bit          snk_burst       = 1'b0;

    // 10 ns clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Frame span: length field plus two, wrapping at 16 bits
    function automatic logic [15:0] frame_span();
        return frame_len + 16'd2;
    endfunction

    // Fold the byte at position q into the sum, marker and checksum-field state
    function automatic void fold_frame_byte(input int unsigned q, input logic [7:0] b,
                                            input int unsigned f);
        if (f < 5 || q >= f) begin
            return;
        end
        if (q + 5 <= f) begin
            acc_sum = acc_sum + {8'h00, b};
        end
        if (q + 5 == f) begin
            marker_good = (b == cfg_marker);
        end
        if (q + 4 == f || q + 3 == f) begin
            sum_field_good = sum_field_good && (b == 8'h00);
        end
        if (q + 2 == f) begin
            sum_field_good = sum_field_good && (b == acc_sum[15:8]);
        end
        if (q + 1 == f) begin
            sum_field_good = sum_field_good && (b == acc_sum[7:0]);
        end
    endfunction

    // Advance the predictor by one accepted item; returns 1 when a verdict is due
    function automatic bit predict_byte(input logic [7:0] b, input logic is_last,
                                        output result_t verdict);
        int unsigned q;
        int unsigned n;
        int unsigned f;
        q = byte_pos;
        n = q + 1;
        verdict.status   = ST_ACCEPT;
        verdict.coverage = COV_FULL;
        if (q == 0) begin
            start_good = (b == cfg_start[15:8]);
        end else if (q == 1) begin
            start_good = start_good && (b == cfg_start[7:0]);
        end else if (q == 2) begin
            frame_len = {b, 8'h00};
        end else if (q == 3) begin
            // Length now known: replay the header, which may hold the trailer fields
            frame_len[7:0] = b;
            f = frame_span();
            acc_sum        = '0;
            marker_good    = 1'b0;
            sum_field_good = 1'b1;
            fold_frame_byte(0, cfg_start[15:8], f);
            fold_frame_byte(1, cfg_start[7:0], f);
            fold_frame_byte(2, frame_len[15:8], f);
            fold_frame_byte(3, b, f);
        end else begin
            fold_frame_byte(q, b, frame_span());
        end
        if (byte_pos != 16'hFFFF) begin
            byte_pos = byte_pos + 16'd1;
        end
        if (!is_last) begin
            return 1'b0;
        end
        f = frame_span();
        if (n < 4 || !start_good || f < 5) begin
            verdict.status = ST_CTRL_ERR;
        end else if (n >= f) begin
            if (!marker_good) begin
                verdict.status = ST_CTRL_ERR;
            end else if (!sum_field_good) begin
                verdict.status = ST_SUM_ERR;
            end
        end else if (n + 4 >= f) begin
            verdict.coverage = COV_END_ONLY;
            if (!marker_good) begin
                verdict.status = ST_CTRL_ERR;
            end
        end else begin
            verdict.coverage = COV_UNCHECKED;
        end
        byte_pos       = '0;
        frame_len      = '0;
        acc_sum        = '0;
        start_good     = 1'b0;
        marker_good    = 1'b0;
        sum_field_good = 1'b0;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Byte channel driver
    // ------------------------------------------------------------------

    // Offer one item after an idle gap, hold it until taken, then predict.
    // Valid is left high on exit so that a zero gap follows without a bubble.
    task automatic send_byte(input logic [7:0] b, input logic is_last, input int unsigned gap,
                             input bit typed, input result_t typed_res);
        result_t predicted;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_byte_value <= b;
        s_last_byte  <= is_last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        bytes_sent++;
        if (is_last) begin
            buffers_sent++;
        end
        if (predict_byte(b, is_last, predicted)) begin
            verdict_q.push_back(typed ? typed_res : predicted);
        end
    endtask

    // Transmit frame_bytes, flagging the final one; no_idle suppresses every gap
    task automatic send_buffer(input bit no_idle);
        int unsigned i;
        int unsigned gap;
        result_t     unused;
        unused = '0;
        for (i = 0; i < frame_bytes.size(); i++) begin
            gap = (no_idle || src_burst) ? 0 : $urandom_range(0, 16);
            send_byte(frame_bytes[i], i == frame_bytes.size() - 1, gap, 1'b0, unused);
        end
        src_burst = ($urandom_range(0, 3) == 0);
    endtask

    // Drop valid and wait until every verdict is in and the pipeline is empty
    task automatic settle();
        s_valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Write the start word, then the end marker, while the block is idle
    task automatic load_registers(input logic [15:0] sw, input logic [7:0] em);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_START_WORD;
        cfg_wdata <= sw;
        @(posedge aclk);
        cfg_index <= REG_END_MARKER;
        cfg_wdata <= {8'h00, em};
        @(posedge aclk);
        cfg_wr_en  <= 1'b0;
        cfg_start  = sw;
        cfg_marker = em;
    endtask

    // ------------------------------------------------------------------
    // Buffer generation
    // ------------------------------------------------------------------

    // Build a well-formed frame of the given span under the current registers.
    // Trailer fields that land inside the header are left as the header has them.
    task automatic build_frame(input int unsigned span);
        int unsigned p;
        logic [15:0] len;
        logic [15:0] csum;
        len = 16'(span - 2);
        frame_bytes.delete();
        frame_bytes.push_back(cfg_start[15:8]);
        frame_bytes.push_back(cfg_start[7:0]);
        frame_bytes.push_back(len[15:8]);
        frame_bytes.push_back(len[7:0]);
        for (p = 4; p < span; p++) begin
            frame_bytes.push_back(8'($urandom));
        end
        if (span - 5 >= 4) begin
            frame_bytes[span - 5] = cfg_marker;
        end
        if (span - 4 >= 4) begin
            frame_bytes[span - 4] = 8'h00;
        end
        if (span - 3 >= 4) begin
            frame_bytes[span - 3] = 8'h00;
        end
        csum = '0;
        for (p = 0; p + 5 <= span; p++) begin
            csum = csum + {8'h00, frame_bytes[p]};
        end
        if (span - 2 >= 4) begin
            frame_bytes[span - 2] = csum[15:8];
        end
        frame_bytes[span - 1] = csum[7:0];
    endtask

    // Mostly well-formed frames with random payload, some damaged, cut short
    // or padded; the rest odd length fields and plain noise.
    task automatic build_random_buffer();
        int unsigned kind;
        int unsigned span;
        int unsigned p;
        int unsigned cut;
        logic [15:0] len;
        kind = $urandom_range(0, 99);
        if (kind < 70) begin
            case ($urandom_range(0, 19))
                0: begin
                    span = $urandom_range(5, 8);
                end
                1: begin
                    span = $urandom_range(100, 300);
                end
                default: begin
                    span = $urandom_range(9, 40);
                end
            endcase
            build_frame(span);
            case ($urandom_range(0, 9))
                0, 1: begin
                    // corrupt one byte anywhere in the frame
                    p = $urandom_range(0, span - 1);
                    frame_bytes[p] = frame_bytes[p] ^ 8'($urandom_range(1, 255));
                end
                2: begin
                    // stop inside or just before the checksum field
                    cut = $urandom_range(span - 4, span - 1);
                    while (frame_bytes.size() > cut) frame_bytes.pop_back();
                end
                3: begin
                    cut = $urandom_range(1, span - 1);
                    while (frame_bytes.size() > cut) frame_bytes.pop_back();
                end
                4: begin
                    // trailing bytes after the frame are to be ignored
                    repeat ($urandom_range(1, 8)) frame_bytes.push_back(8'($urandom));
                end
                default: begin
                end
            endcase
        end else if (kind < 85) begin
            case ($urandom_range(0, 7))
                0: len = 16'h0000;
                1: len = 16'h0001;
                2: len = 16'h0002;
                3: len = 16'h0003;
                4: len = 16'hFFFD;
                5: len = 16'hFFFE;
                6: len = 16'hFFFF;
                default: len = 16'($urandom);
            endcase
            frame_bytes.delete();
            frame_bytes.push_back(cfg_start[15:8]);
            frame_bytes.push_back(cfg_start[7:0]);
            frame_bytes.push_back(len[15:8]);
            frame_bytes.push_back(len[7:0]);
            repeat ($urandom_range(0, 10)) frame_bytes.push_back(8'($urandom));
        end else begin
            frame_bytes.delete();
            repeat ($urandom_range(1, 20)) frame_bytes.push_back(8'($urandom));
        end
    endtask

    // ------------------------------------------------------------------
    // Result channel: random back-pressure and checking
    // ------------------------------------------------------------------

    initial begin
        int unsigned gap;
        result_t     want;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            gap = snk_burst ? 0 : $urandom_range(0, 16);
            if (gap != 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            // A verdict was taken at this edge: match it against the oldest one owed
            if (verdict_q.size() == 0) begin
                $display("%0t: unexpected result, status %0d coverage %0d",
                         $time, m_status, m_coverage);
                mismatches++;
            end else begin
                want = verdict_q.pop_front();
                results_checked++;
                if (m_status !== want.status) begin
                    $display("%0t: status mismatch, expected %0d, got %0d",
                             $time, want.status, m_status);
                    mismatches++;
                end
                if (m_coverage !== want.coverage) begin
                    $display("%0t: coverage mismatch, expected %0d, got %0d",
                             $time, want.coverage, m_coverage);
                    mismatches++;
                end
            end
            if ($urandom_range(0, 7) == 0) begin
                snk_burst = ~snk_burst;
            end
        end
    end

    // Watchdog: give up when neither channel has moved an item for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                     $time, STALL_LIMIT, verdict_q.size());
            $display("CHECKS FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    initial begin
        int unsigned i;
        int unsigned gap;
        int unsigned ph;
        int unsigned random_items;
        int unsigned target;
        result_t     typed_res;

        aresetn      <= 1'b0;
        cfg_wr_en    <= 1'b0;
        cfg_index    <= REG_START_WORD;
        cfg_wdata    <= '0;
        s_valid      <= 1'b0;
        s_byte_value <= '0;
        s_last_byte  <= 1'b0;

        // Hand-made buffers under the reset register values
        directed_rows = '{
            // buffer of one byte: too short for a header
            '{8'h4E, 1'b1, 1'b1, ST_CTRL_ERR, COV_FULL},
            // complete frame, span 9, checksum 0x0114
            '{8'h4E, 1'b0, 1'b0, ST_ACCEPT,   COV_FULL},
            '{8'h57, 1'b0, 1'b0, ST_ACCEPT,   COV_FULL},
            '{8'h00, 1'b0, 1'b0, ST_ACCEPT,   COV_FULL},
            '{8'h07, 1'b0, 1'b0, ST_ACCEPT,   COV_FULL},
            '{8'h68, 1'b0, 1'b0, ST_ACCEPT,   COV_FULL},
            '{8'h00, 1'b0, 1'b0, ST_ACCEPT,   COV_FULL},
            '{8'h00, 1'b0, 1'b0, ST_ACCEPT,   COV_FULL},
            '{8'h01, 1'b0, 1'b0, ST_ACCEPT,   COV_FULL},
            '{8'h14, 1'b1, 1'b1, ST_ACCEPT,   COV_FULL},
            // same frame with the low checksum byte off by one
            '{8'h4E, 1'b0, 1'b0, ST_ACCEPT,   COV_FULL},
            '{8'h57, 1'b0, 1'b0, ST_ACCEPT,   COV_FULL},
            '{8'h00, 1'b0, 1'b0, ST_ACCEPT,   COV_FULL},
            '{8'h07, 1'b0, 1'b0, ST_ACCEPT,   COV_FULL},
            '{8'h68, 1'b0, 1'b0, ST_ACCEPT,   COV_FULL},
            '{8'h00, 1'b0, 1'b0, ST_ACCEPT,   COV_FULL},
            '{8'h00, 1'b0, 1'b0, ST_ACCEPT,   COV_FULL},
            '{8'h01, 1'b0, 1'b0, ST_ACCEPT,   COV_FULL},
            '{8'h15, 1'b1, 1'b1, ST_SUM_ERR,  COV_FULL},
            // span 6: end marker falls on the header, only the marker is checked
            '{8'h4E, 1'b0, 1'b0, ST_ACCEPT,   COV_FULL},
            '{8'h57, 1'b0, 1'b0, ST_ACCEPT,   COV_FULL},
            '{8'h00, 1'b0, 1'b0, ST_ACCEPT,   COV_FULL},
            '{8'h04, 1'b1, 1'b0, ST_ACCEPT,   COV_FULL},
            // length 0xFFFF: span wraps to 1
            '{8'h4E, 1'b0, 1'b0, ST_ACCEPT,   COV_FULL},
            '{8'h57, 1'b0, 1'b0, ST_ACCEPT,   COV_FULL},
            '{8'hFF, 1'b0, 1'b0, ST_ACCEPT,   COV_FULL},
            '{8'hFF, 1'b1, 1'b1, ST_CTRL_ERR, COV_FULL}
        };

        // Hold reset low, then release it for good
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        random_items = 0;
        for (ph = 0; ph < 6; ph++) begin
            if (ph == 0) begin
                for (i = 0; i < DIRECTED_ROWS; i++) begin
                    gap = src_burst ? 0 : $urandom_range(0, 16);
                    typed_res.status   = directed_rows[i].st;
                    typed_res.coverage = directed_rows[i].cv;
                    send_byte(directed_rows[i].value, directed_rows[i].last, gap,
                              directed_rows[i].typed, typed_res);
                end
            end else begin
                // Change registers only once the block has gone quiet
                settle();
                case (ph)
                    1: load_registers(16'h0000, 8'h00);
                    2: load_registers(16'hFFFF, 8'hFF);
                    5: load_registers(START_WORD_RST, END_MARKER_RST);
                    default: load_registers(16'($urandom), 8'($urandom));
                endcase
            end

            target = random_items + ITEMS_PER_SETTING;
            while (random_items < target) begin
                build_random_buffer();
                random_items += frame_bytes.size();
                send_buffer(1'b0);
            end
        end

        settle();
        $display("Drove %0d bytes in %0d buffers across six register settings,",
                 bytes_sent, buffers_sent);
        $display("hand-made frames first; %0d results compared, %0d mismatches",
                 results_checked, mismatches);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/bfvc_pkg.sv
design/bfvc_track.sv
design/bms_frame_validity_checker_core.sv
tb/tb.sv
